// ===== sv/drbg_pkg.sv =====
`timescale 1ns / 1ps
package drbg_pkg;
	localparam int MaxBlocksDef = 64;
	localparam int CntW = 49;
	localparam logic [CntW-1:0] IntervalReset = 49'h1000000000000;

	typedef enum logic [2:0] {
		MODE_LOAD_ENT = 3'd0,
		MODE_LOAD_ADD = 3'd1,
		MODE_INST     = 3'd2,
		MODE_RESEED   = 3'd3,
		MODE_GEN      = 3'd4
	} mode_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RESEED = 2'd1;
	localparam logic [1:0] ST_NOINST = 2'd2;

	typedef struct packed {
		logic         start;
		logic [255:0] key;
		logic [127:0] blk;
	} aes_req_t;

	typedef struct packed {
		logic         done;
		logic [127:0] blk;
	} aes_rsp_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction
endpackage

// ===== sv/ctr_drbg_aes256_top.sv =====
`timescale 1ns / 1ps
// deterministic random bit generator in counter mode over AES-256, no derivation function
// input channel (in_valid/in_stall): one command per transaction; mode 0/1
//   load a 64-bit seed word, 2 instantiates, 3 reseeds, 4 generates
// output channel (out_valid/out_stall): one 128-bit block per transaction,
//   last marks the final one of a command, status carries errors
// the shared round unit does one AES round per cycle
// a load leaves the sequencer idle, so the next transaction can follow at once
// instantiate and reseed run three blocks before they answer; the sequencer is back
//   in idle, ready for the next command, when the answer appears
// an error answers through the response state once the output is free
// generate runs one AES block per output block and then a closing update, with
//   another update up front when additional input is used
// one command is handled at a time and in_stall is high until it is finished
// a stalled output holds its block and the sequencer waits for it
// the reseed limit register sits at APB address 0 with 64-bit data
// reset clears key, V, counter, buffers and the instantiated flag, and the
//   reseed limit returns to 2^48
module ctr_drbg_aes256_top import drbg_pkg::*; #(
	parameter int MAX_BLOCKS = MaxBlocksDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  word_index,
	input  logic [63:0] data_word,
	input  logic        use_additional,
	input  logic [6:0]  block_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_high,
	output logic [63:0] block_low,
	output logic        last,
	output logic [1:0]  status
);
	localparam int BW = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_UPD, S_GEN, S_WAIT, S_OUT, S_RESP
	} state_t;

	state_t         state_q;
	logic [255:0]   key_q;
	logic [127:0]   v_q;
	logic [CntW-1:0] cnt_q, intv_q;
	logic           inst_q;
	logic [383:0]   ent_q, add_q, seed_q, tmp_q;
	logic [1:0]     ub_q;
	logic           gen_q, final_q;
	logic [BW-1:0]  todo_q;
	logic [63:0]    hi_q, lo_q;
	logic           lastq_q, ov_q;
	logic [1:0]     st_q, err_q;
	logic           start_q;
	aes_req_t       req;
	aes_rsp_t       rsp;
	logic [127:0]   vinc;
	logic [383:0]   tnew;
	logic [BW-1:0]  cnt_sat;
	logic [8:0]     widx;

	assign vinc = v_q + 128'd1;
	assign req.start = start_q;
	assign req.key = key_q;
	assign req.blk = vinc;

	drbg_aes u_aes (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		tnew = {tmp_q[255:0], rsp.blk};
		if (block_count == 7'd0) cnt_sat = BW'(1);
		else if (block_count > 7'(MAX_BLOCKS)) cnt_sat = BW'(MAX_BLOCKS);
		else cnt_sat = BW'(block_count);
		widx = 9'(9'd383 - {word_index, 6'd0});
	end

	assign pready = 1'b1;
	assign prdata = paddr ? 64'd0 : {15'd0, intv_q};
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = ov_q;
	assign block_high = hi_q;
	assign block_low = lo_q;
	assign last = lastq_q;
	assign status = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			key_q    <= '0;
			v_q      <= '0;
			cnt_q    <= '0;
			intv_q   <= IntervalReset;
			inst_q   <= 1'b0;
			ent_q    <= '0;
			add_q    <= '0;
			seed_q   <= '0;
			tmp_q    <= '0;
			ov_q     <= 1'b0;
			start_q  <= 1'b0;
			ub_q     <= '0;
			gen_q    <= 1'b0;
			final_q  <= 1'b0;
			todo_q   <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			lastq_q  <= 1'b0;
			st_q     <= ST_OK;
			err_q    <= ST_OK;
		end else begin
			start_q <= 1'b0;
			if (psel && penable && pwrite && pready) begin
				if (!paddr) intv_q <= pwdata[CntW-1:0];
			end
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (mode)
							MODE_LOAD_ENT: if (word_index < 3'd6) ent_q[widx -: 64] <= data_word;
							MODE_LOAD_ADD: if (word_index < 3'd6) add_q[widx -: 64] <= data_word;
							MODE_INST, MODE_RESEED: begin
								if (mode == MODE_RESEED && !inst_q) begin
									err_q <= ST_NOINST; state_q <= S_RESP;
								end else begin
									seed_q <= ent_q ^ (use_additional ? add_q : '0);
									if (mode == MODE_INST) begin
										key_q <= '0; v_q <= '0;
									end
									gen_q <= 1'b0; ub_q <= '0; start_q <= 1'b1;
									err_q <= ST_OK; state_q <= S_UPD;
								end
							end
							MODE_GEN: begin
								if (!inst_q) begin
									err_q <= ST_NOINST; state_q <= S_RESP;
								end else if (cnt_q > intv_q) begin
									err_q <= ST_RESEED; state_q <= S_RESP;
								end else begin
									seed_q <= use_additional ? add_q : '0;
									todo_q <= cnt_sat; gen_q <= 1'b1; final_q <= 1'b0;
									err_q <= ST_OK; ub_q <= '0;
									if (use_additional) begin
										start_q <= 1'b1; state_q <= S_UPD;
									end else begin
										start_q <= 1'b1; state_q <= S_GEN;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_UPD: begin
					if (rsp.done) begin
						tmp_q <= tnew;
						if (ub_q == 2'd2) begin
							key_q <= tnew[383:128] ^ seed_q[383:128];
							v_q <= tnew[127:0] ^ seed_q[127:0];
							if (!gen_q) begin
								cnt_q <= CntW'(1); inst_q <= 1'b1; state_q <= S_RESP;
							end else if (final_q) begin
								cnt_q <= cnt_q + CntW'(1); state_q <= S_IDLE;
							end else begin
								start_q <= 1'b1; state_q <= S_GEN;
							end
						end else begin
							v_q <= vinc; ub_q <= ub_q + 2'd1; start_q <= 1'b1;
						end
					end
				end
				S_GEN: begin
					if (rsp.done) begin
						v_q <= vinc;
						todo_q <= todo_q - BW'(1);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!ov_q) begin
						hi_q <= rsp.blk[127:64]; lo_q <= rsp.blk[63:0];
						lastq_q <= (todo_q == '0);
						st_q <= ST_OK;
						ov_q <= 1'b1; state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if (todo_q == '0) begin
							final_q <= 1'b1; ub_q <= '0; start_q <= 1'b1; state_q <= S_UPD;
						end else begin
							start_q <= 1'b1; state_q <= S_GEN;
						end
					end
				end
				S_RESP: begin
					if (!ov_q) begin
						hi_q <= '0; lo_q <= '0; lastq_q <= 1'b1; st_q <= err_q; ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/drbg_aes.sv =====
`timescale 1ns / 1ps
module drbg_aes import drbg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  aes_req_t req,
	output aes_rsp_t rsp
);
	// one round per cycle, round key schedule rolled forward alongside
	logic [127:0] st_q;
	logic [255:0] kw_q;
	logic [3:0]   rnd_q;
	logic [7:0]   rcon_q;
	logic         busy_q;
	logic         done_q;

	logic [127:0] rk;
	logic [127:0] sb, sr, mc, nxt;
	logic [255:0] kn;
	logic [31:0]  w0, w1, w2, w3, w4, w5, w6, w7, tt, tu;
	logic [7:0]   a0, a1, a2, a3;

	always_comb begin
		// key words for round rnd_q: even rounds use upper half of the window
		rk = rnd_q[0] ? kw_q[127:0] : kw_q[255:128];
		for (int i = 0; i < 16; i++) begin
			sb[127-8*i -: 8] = sbox(st_q[127-8*i -: 8]);
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sr[127-8*(r+4*c) -: 8] = sb[127-8*(r+4*((c+r)%4)) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = sr[127-32*c -: 8];
			a1 = sr[119-32*c -: 8];
			a2 = sr[111-32*c -: 8];
			a3 = sr[103-32*c -: 8];
			mc[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			mc[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			mc[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			mc[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		nxt = ((rnd_q == 4'd14) ? sr : mc) ^ rk;
		{w0, w1, w2, w3, w4, w5, w6, w7} = kw_q;
		tt = sub_word({w7[23:0], w7[31:24]}) ^ {rcon_q, 24'h0};
		w0 = w0 ^ tt;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		tu = sub_word(w3);
		w4 = w4 ^ tu;
		w5 = w5 ^ w4;
		w6 = w6 ^ w5;
		w7 = w7 ^ w6;
		kn = {w0, w1, w2, w3, w4, w5, w6, w7};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			kw_q   <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
			rcon_q <= 8'h01;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				st_q   <= req.blk ^ req.key[255:128];
				kw_q   <= req.key;
				rnd_q  <= 4'd1;
				rcon_q <= 8'h01;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				st_q <= nxt;
				if (rnd_q[0]) begin
					kw_q   <= kn;
					rcon_q <= xt(rcon_q);
				end
				if (rnd_q == 4'd14) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				rnd_q <= rnd_q + 4'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.blk  = st_q;
endmodule

// ===== sv/drbg_checker.sv =====
`timescale 1ns / 1ps
module drbg_props import drbg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  mode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] block_high,
	input logic        last,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(block_high) && $stable(status))
		else $error("stalled output changed");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && block_high == 64'd0)
		else $error("error result not final");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (mode == MODE_INST || mode == MODE_RESEED || mode == MODE_GEN)
		|=> in_stall)
		else $error("command accepted without going busy");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status");
endmodule

bind ctr_drbg_aes256_top drbg_props u_chk (.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
	.in_stall(in_stall), .mode(mode), .out_valid(out_valid), .out_stall(out_stall),
	.block_high(block_high), .last(last), .status(status));

// ===== test/drbg_checker.sv =====
`timescale 1ns / 1ps
module drbg_checker import drbg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  word_index,
	input  logic [63:0] data_word,
	input  logic        use_additional,
	input  logic [6:0]  block_count,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	input  logic        last,
	input  logic [1:0]  status,
	output int          fails,
	output int          pending
);
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        lst;
		logic [1:0]  st;
	} drbg_block_t;

	drbg_block_t blocks_due[$];
	logic [7:0]      sb [256];
	logic [255:0]    key_q;
	logic [127:0]    v_q;
	logic [CntW-1:0] reseed_cnt;
	logic [CntW-1:0] interval;
	logic            inst_q;
	logic [383:0]    ent_buf;
	logic [383:0]    add_buf;

	function automatic logic [7:0] dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= x;
			x = dbl(x);
		end
		return p;
	endfunction

	initial begin
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 0;
			for (int y = 1; y < 256; y++)
				if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
			sb[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
	end

	function automatic logic [31:0] subw(input logic [31:0] w);
		return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
	endfunction

	function automatic logic [127:0] aes256(input logic [255:0] k, input logic [127:0] pt);
		logic [31:0]  w [60];
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [31:0]  tmp;
		logic [7:0]   rc;
		logic [7:0]   a0, a1, a2, a3;
		logic [127:0] ct;
		rc = 8'h01;
		for (int i = 0; i < 8; i++) w[i] = k[255-32*i -: 32];
		for (int i = 8; i < 60; i++) begin
			tmp = w[i-1];
			if (i % 8 == 0) begin
				tmp = subw({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
				rc = dbl(rc);
			end else if (i % 8 == 4) begin
				tmp = subw(tmp);
			end
			w[i] = w[i-8] ^ tmp;
		end
		for (int i = 0; i < 16; i++)
			s[i] = pt[127-8*i -: 8] ^ 8'(w[i/4] >> (24 - 8*(i%4)));
		for (int rnd = 1; rnd <= 14; rnd++) begin
			for (int i = 0; i < 16; i++) s[i] = sb[s[i]];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[r+4*c] = s[r+4*((c+r)%4)];
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				if (rnd < 14) begin
					s[4*c]   = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
					s[4*c+1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
					s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
					s[4*c+3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
				end else begin
					s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
				end
			end
			for (int i = 0; i < 16; i++)
				s[i] ^= 8'(w[4*rnd + i/4] >> (24 - 8*(i%4)));
		end
		for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
		return ct;
	endfunction

	task automatic drbg_refresh(input logic [383:0] data);
		logic [383:0] tmp;
		for (int b = 0; b < 3; b++) begin
			v_q = v_q + 128'd1;
			tmp[383-128*b -: 128] = aes256(key_q, v_q);
		end
		tmp ^= data;
		key_q = tmp[383:128];
		v_q = tmp[127:0];
	endtask

	task automatic push_status(input logic [1:0] st);
		blocks_due.push_back('{hi: 64'h0, lo: 64'h0, lst: 1'b1, st: st});
	endtask

	task automatic predict_command();
		logic [383:0] seed;
		logic [127:0] blk;
		int n;
		case (mode)
			MODE_LOAD_ENT: if (word_index < 6) ent_buf[383-64*word_index -: 64] = data_word;
			MODE_LOAD_ADD: if (word_index < 6) add_buf[383-64*word_index -: 64] = data_word;
			MODE_INST, MODE_RESEED: begin
				if (mode == MODE_RESEED && !inst_q) begin
					push_status(ST_NOINST);
				end else begin
					seed = ent_buf ^ (use_additional ? add_buf : 384'h0);
					if (mode == MODE_INST) begin
						key_q = '0;
						v_q = '0;
					end
					drbg_refresh(seed);
					reseed_cnt = CntW'(1);
					inst_q = 1'b1;
					push_status(ST_OK);
				end
			end
			MODE_GEN: begin
				if (!inst_q) begin
					push_status(ST_NOINST);
				end else if (reseed_cnt > interval) begin
					push_status(ST_RESEED);
				end else begin
					n = int'(block_count);
					if (n == 0) n = 1;
					if (n > MaxBlocksDef) n = MaxBlocksDef;
					seed = use_additional ? add_buf : 384'h0;
					if (use_additional) drbg_refresh(seed);
					for (int k = 0; k < n; k++) begin
						v_q = v_q + 128'd1;
						blk = aes256(key_q, v_q);
						blocks_due.push_back('{hi: blk[127:64], lo: blk[63:0],
							lst: (k == n - 1), st: ST_OK});
					end
					drbg_refresh(seed);
					reseed_cnt = reseed_cnt + CntW'(1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fails++;
	endtask

	initial begin
		fails = 0;
		pending = 0;
		key_q = '0;
		v_q = '0;
		reseed_cnt = '0;
		interval = IntervalReset;
		inst_q = 1'b0;
		ent_buf = '0;
		add_buf = '0;
	end

	always @(posedge clk) begin
		drbg_block_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (blocks_due.size() == 0) begin
					report("output block with nothing expected");
				end else begin
					e = blocks_due.pop_front();
					if (block_high !== e.hi)
						report($sformatf("block_high %h expected %h", block_high, e.hi));
					if (block_low !== e.lo)
						report($sformatf("block_low %h expected %h", block_low, e.lo));
					if (last !== e.lst)
						report($sformatf("last %b expected %b", last, e.lst));
					if (status !== e.st)
						report($sformatf("status %0d expected %0d", status, e.st));
				end
			end
			if (in_valid && !in_stall) predict_command();
			if (psel && penable && pwrite && pready) begin
				if (paddr == 1'b0) interval = pwdata[CntW-1:0];
			end
			pending = blocks_due.size();
		end
	end
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top import drbg_pkg::*; ();
	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [2:0]  mode, word_index;
	logic [63:0] data_word;
	logic        use_additional;
	logic [6:0]  block_count;
	logic        out_valid, out_stall;
	logic [63:0] block_high, block_low;
	logic        last;
	logic [1:0]  status;
	int          fails, pending;
	bit          quiet;
	bit          hold_now;

	ctr_drbg_aes256_top dut (.*);

	drbg_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (hold_now) begin
				out_stall = 1;
				repeat (600) @(negedge clk);
				hold_now = 0;
				out_stall = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	task automatic send(input logic [2:0] m, input logic [2:0] idx, input logic [63:0] w,
			input logic ua, input logic [6:0] bc);
		mode = m;
		word_index = idx;
		data_word = w;
		use_additional = ua;
		block_count = bc;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	task automatic apb_write(input logic a, input logic [63:0] d);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	task automatic set_interval(input logic [CntW-1:0] v);
		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		apb_write(1'b0, 64'(v));
	endtask

	task automatic random_command();
		int r;
		logic [2:0] idx;
		logic [6:0] bc;
		r = $urandom_range(0, 99);
		idx = 3'($urandom_range(0, 5));
		bc = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(1, 4)) : 7'($urandom);
		if (r < 40)
			send(MODE_LOAD_ENT, idx, {$urandom, $urandom}, 1'($urandom), 7'($urandom));
		else if (r < 60)
			send(MODE_LOAD_ADD, idx, {$urandom, $urandom}, 1'($urandom), 7'($urandom));
		else if (r < 85)
			send(MODE_GEN, 3'($urandom), {$urandom, $urandom}, 1'($urandom), bc);
		else if (r < 90)
			send(MODE_RESEED, 3'($urandom), {$urandom, $urandom}, 1'($urandom),
				7'($urandom));
		else if (r < 93)
			send(MODE_INST, 3'($urandom), {$urandom, $urandom}, 1'($urandom), 7'($urandom));
		else if (r < 96)
			send(3'($urandom_range(5, 7)), 3'($urandom), {$urandom, $urandom},
				1'($urandom), 7'($urandom));
		else
			send(3'($urandom_range(0, 1)), 3'($urandom_range(6, 7)), {$urandom, $urandom},
				1'($urandom), 7'($urandom));
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_valid = 0;
		mode = MODE_LOAD_ENT;
		word_index = 0;
		data_word = 0;
		use_additional = 0;
		block_count = 0;
		quiet = 0;
		hold_now = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(MODE_GEN, 0, 0, 0, 1);
		send(MODE_RESEED, 0, 0, 1, 1);
		for (int i = 0; i < 6; i++)
			send(MODE_LOAD_ENT, 3'(i), (i % 2) ? 64'h0 : '1, 0, 0);
		send(MODE_LOAD_ENT, 6, 64'h1234, 1, 0);
		send(MODE_LOAD_ADD, 7, '1, 1, 0);
		send(3'd5, 0, 0, 0, 1);
		send(3'd7, 7, '1, 1, 7'h7f);
		send(MODE_LOAD_ADD, 0, '1, 0, 0);
		send(MODE_LOAD_ADD, 5, 64'h8000_0000_0000_0001, 0, 0);
		send(MODE_INST, 0, 0, 1, 0);
		send(MODE_GEN, 0, 0, 0, 0);
		send(MODE_GEN, 0, 0, 1, 7'h7f);
		send(MODE_GEN, 0, 0, 1, 64);
		send(MODE_RESEED, 0, 0, 0, 1);
		send(MODE_INST, 0, 0, 0, 1);

		set_interval(1);
		send(MODE_GEN, 0, 0, 0, 1);
		send(MODE_GEN, 0, 0, 0, 2);
		send(MODE_RESEED, 0, 0, 1, 1);
		send(MODE_GEN, 0, 0, 1, 1);
		set_interval({CntW{1'b1}});

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) begin
				set_interval(CntW'($urandom_range(1, 4)));
				send(MODE_INST, 0, 0, 1, 0);
				hold_now = 1;
				send(MODE_GEN, 0, 0, 0, 20);
			end
			if (ph == 2) set_interval({CntW{1'b1}});
			if (ph == 3) begin
				set_interval(IntervalReset);
				quiet = 1;
			end
			for (int i = 0; i < 50; i++) random_command();
		end

		in_valid = 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
